[rtl/tbm_pkg.sv]
// Shared types, constants and arithmetic helpers of the temporal band-pass magnifier.
// Used by every module of the block but tbm_ram. Depends on nothing.
package tbm_pkg;

    localparam int STORE_ENTRIES   = 65536;
    localparam int ADDR_BITS       = $clog2(STORE_ENTRIES);
    localparam int PIXEL_ADDR_BITS = 16;
    localparam int SAMPLE_BITS     = 16;
    localparam int LP_EXTRA        = 4;
    localparam int LP_BITS         = SAMPLE_BITS + LP_EXTRA;
    localparam int NUM_CH          = 3;
    localparam int LP_WORD_BITS    = NUM_CH * LP_BITS;
    localparam int COEF_BITS       = 16;
    localparam int LEVEL_BITS      = 3;
    localparam int GAIN_BITS       = COEF_BITS + 1;
    localparam int BAND_BITS       = LP_BITS + 1;
    localparam int LP_PROD_BITS    = LP_BITS + 1 + COEF_BITS + 1;
    localparam int PROD_G_BITS     = BAND_BITS + GAIN_BITS;
    localparam int PROD_C_BITS     = PROD_G_BITS + COEF_BITS + 1;
    localparam int WIDE_BITS       = PROD_C_BITS + 1;
    localparam int GAIN_SHIFT      = LP_EXTRA + 8;
    localparam int CHROMA_SHIFT    = LP_EXTRA + 16;

    localparam int QUEUE_DEPTH     = 4;
    localparam int Q_PTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_BITS      = Q_PTR_BITS + 1;
    localparam int OUT_DEPTH       = 8;
    localparam int OUT_PTR_BITS    = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_BITS    = OUT_PTR_BITS + 1;

    localparam int CFG_ADDR_BITS   = 5;
    localparam int CFG_DATA_BITS   = 32;
    localparam int CFG_INDEX_BITS  = CFG_ADDR_BITS - 2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF_FAST  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CUTOFF_SLOW  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALPHA_CAP    = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CHROMA_ATTEN = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TOP_LEVEL    = 3'd4;

    localparam logic [COEF_BITS-1:0]  RST_CUTOFF_FAST  = 16'd26214;
    localparam logic [COEF_BITS-1:0]  RST_CUTOFF_SLOW  = 16'd3277;
    localparam logic [COEF_BITS-1:0]  RST_ALPHA_CAP    = 16'd2560;
    localparam logic [COEF_BITS-1:0]  RST_CHROMA_ATTEN = 16'd256;
    localparam logic [LEVEL_BITS-1:0] RST_TOP_LEVEL    = 3'd4;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [LP_BITS-1:0]     lp_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_ZERO,
        OP_UPDATE
    } op_t;

    typedef struct packed {
        logic [PIXEL_ADDR_BITS-1:0] pixel_addr;
        logic [LEVEL_BITS-1:0]      level;
        sample_t                    sample_ch0;
        sample_t                    sample_ch1;
        sample_t                    sample_ch2;
        logic signed [15:0]         level_gain;
        logic                       first_frame;
    } in_item_t;

    typedef struct packed {
        sample_t out_ch0;
        sample_t out_ch1;
        sample_t out_ch2;
    } out_item_t;

    typedef struct packed {
        logic [COEF_BITS-1:0]  cutoff_fast;
        logic [COEF_BITS-1:0]  cutoff_slow;
        logic [COEF_BITS-1:0]  alpha_cap;
        logic [COEF_BITS-1:0]  chroma_atten;
        logic [LEVEL_BITS-1:0] top_level;
    } cfg_t;

    typedef struct packed {
        op_t                         op;
        logic [ADDR_BITS-1:0]        addr;
        sample_t [NUM_CH-1:0]        x;
        logic signed [GAIN_BITS-1:0] gain;
    } q_entry_t;

    // One first-order low-pass step: lp + round(c * (x - lp) / 2^16).
    function automatic lp_t lp_step(input lp_t lp, input lp_t x12,
                                    input logic [COEF_BITS-1:0] c);
        logic signed [LP_BITS:0]        d;
        logic signed [LP_PROD_BITS-1:0] p;
        logic signed [LP_PROD_BITS-1:0] r;
        d = {x12[LP_BITS-1], x12} - {lp[LP_BITS-1], lp};
        p = d * $signed({1'b0, c});
        r = (p + (LP_PROD_BITS'(1) <<< (COEF_BITS - 1))) >>> COEF_BITS;
        return lp + lp_t'(r[LP_BITS-1:0]);
    endfunction

    // Clamp a wide signed value to the sample range.
    function automatic sample_t sat_sample(input logic signed [WIDE_BITS-1:0] v);
        logic signed [WIDE_BITS-1:0] hi;
        logic signed [WIDE_BITS-1:0] lo;
        hi = (WIDE_BITS'(1) <<< (SAMPLE_BITS - 1)) - WIDE_BITS'(1);
        lo = -hi - WIDE_BITS'(1);
        if (v > hi) begin
            return hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            return lo[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

endpackage

[rtl/temporal_bandpass_magnifier_top.sv]
// Temporal band-pass magnifier. A transaction passes the front queue, the back-end stages
// and the output FIFO to m_valid; throughput: one transaction per cycle while the FIFO has
// room, set by the single read and single write port of the two low-pass store RAMs plus a
// one-entry write forward. Reset (synchronous, active low) empties the queue, pipeline and
// output FIFO and returns the registers to defaults; the store is not cleared and must be
// loaded by a first frame. Depends on tbm_pkg, tbm_cfg, tbm_front, tbm_back and tbm_ram.
module temporal_bandpass_magnifier_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tbm_pkg::in_item_t                 s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tbm_pkg::out_item_t                m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tbm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tbm_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import tbm_pkg::*;

    cfg_t     cfg;
    logic     q_valid;
    logic     q_pop;
    q_entry_t q_entry;

    tbm_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tbm_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    tbm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[rtl/tbm_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
// Read during a write to the same address returns the old contents. No dependencies.
module tbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/tbm_cfg.sv]
// APB-style configuration registers of the band-pass magnifier.
// Depends on tbm_pkg for the register map and reset values.
module tbm_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [tbm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input  logic [tbm_pkg::CFG_DATA_BITS-1:0] pwdata,
    output logic [tbm_pkg::CFG_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output tbm_pkg::cfg_t                     cfg
);
    import tbm_pkg::*;

    cfg_t                      cfg_reg;
    logic                      wr_en;
    logic [CFG_INDEX_BITS-1:0] index;

    assign index  = paddr[CFG_ADDR_BITS-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cutoff_fast  <= RST_CUTOFF_FAST;
            cfg_reg.cutoff_slow  <= RST_CUTOFF_SLOW;
            cfg_reg.alpha_cap    <= RST_ALPHA_CAP;
            cfg_reg.chroma_atten <= RST_CHROMA_ATTEN;
            cfg_reg.top_level    <= RST_TOP_LEVEL;
        end else if (wr_en) begin
            case (index)
                REG_CUTOFF_FAST:  cfg_reg.cutoff_fast  <= pwdata[COEF_BITS-1:0];
                REG_CUTOFF_SLOW:  cfg_reg.cutoff_slow  <= pwdata[COEF_BITS-1:0];
                REG_ALPHA_CAP:    cfg_reg.alpha_cap    <= pwdata[COEF_BITS-1:0];
                REG_CHROMA_ATTEN: cfg_reg.chroma_atten <= pwdata[COEF_BITS-1:0];
                REG_TOP_LEVEL:    cfg_reg.top_level    <= pwdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            REG_CUTOFF_FAST:  prdata = CFG_DATA_BITS'(cfg_reg.cutoff_fast);
            REG_CUTOFF_SLOW:  prdata = CFG_DATA_BITS'(cfg_reg.cutoff_slow);
            REG_ALPHA_CAP:    prdata = CFG_DATA_BITS'(cfg_reg.alpha_cap);
            REG_CHROMA_ATTEN: prdata = CFG_DATA_BITS'(cfg_reg.chroma_atten);
            REG_TOP_LEVEL:    prdata = CFG_DATA_BITS'(cfg_reg.top_level);
            default:          prdata = '0;
        endcase
    end

endmodule

[rtl/tbm_front.sv]
// Front end: accepts pixel transactions, classifies them and queues them for the back end.
// Depends on tbm_pkg for the transaction and queue entry types.
module tbm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  tbm_pkg::cfg_t       cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  tbm_pkg::in_item_t   s_data,
    output logic                q_valid,
    output tbm_pkg::q_entry_t   q_entry,
    input  logic                q_pop
);
    import tbm_pkg::*;

    q_entry_t              q_mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg;
    logic [Q_PTR_BITS-1:0] rd_ptr_reg;
    logic [Q_CNT_BITS-1:0] count_reg;
    logic                  push;
    logic                  gain_below_cap;
    q_entry_t              entry_next;

    assign s_ready = (count_reg != Q_CNT_BITS'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign q_entry = q_mem_reg[rd_ptr_reg];

    always_comb begin
        gain_below_cap = $signed(s_data.level_gain) < $signed({1'b0, cfg.alpha_cap});
        entry_next.addr = ADDR_BITS'(s_data.pixel_addr);
        entry_next.x[0] = s_data.sample_ch0;
        entry_next.x[1] = s_data.sample_ch1;
        entry_next.x[2] = s_data.sample_ch2;
        entry_next.gain = gain_below_cap ? {s_data.level_gain[15], s_data.level_gain}
                                         : {1'b0, cfg.alpha_cap};
        // A first frame wins over the level test: the entry is loaded whatever the level.
        if (s_data.first_frame) begin
            entry_next.op = OP_LOAD;
        end else if (s_data.level == '0 || s_data.level >= cfg.top_level) begin
            entry_next.op = OP_ZERO;
        end else begin
            entry_next.op = OP_UPDATE;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem_reg[wr_ptr_reg] <= entry_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_BITS'(1);
            end
            if (q_pop) begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_BITS'(1);
            end
            if (push && !q_pop) begin
                count_reg <= count_reg + Q_CNT_BITS'(1);
            end else if (q_pop && !push) begin
                count_reg <= count_reg - Q_CNT_BITS'(1);
            end
        end
    end

endmodule

[rtl/tbm_back.sv]
// Back end: reads the low-pass store, updates both filters, scales the band-pass and
// buffers results in an output FIFO. Depends on tbm_pkg and tbm_ram.
module tbm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  tbm_pkg::cfg_t       cfg,
    input  logic                q_valid,
    input  tbm_pkg::q_entry_t   q_entry,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output tbm_pkg::out_item_t  m_data
);
    import tbm_pkg::*;

    // Stage 1: store data returns, filters update and write back.
    logic                          v1_reg;
    q_entry_t                      s1_reg;
    // Stage 2: band-pass times gain.
    logic                          v2_reg;
    op_t                           op2_reg;
    sample_t [NUM_CH-1:0]          x2_reg;
    logic signed [GAIN_BITS-1:0]   g2_reg;
    logic signed [BAND_BITS-1:0]   band2_reg [NUM_CH];
    // Stage 3: chroma scale, rounding and saturation.
    logic                          v3_reg;
    op_t                           op3_reg;
    sample_t [NUM_CH-1:0]          x3_reg;
    logic signed [PROD_G_BITS-1:0] prod3_reg [NUM_CH];

    // Last write to the store, for a read that raced it.
    logic                          fwd_v_reg;
    logic [ADDR_BITS-1:0]          fwd_addr_reg;
    logic [LP_WORD_BITS-1:0]       fwd_fast_reg;
    logic [LP_WORD_BITS-1:0]       fwd_slow_reg;

    out_item_t                     fifo_reg [OUT_DEPTH];
    logic [OUT_PTR_BITS-1:0]       fifo_wr_reg;
    logic [OUT_PTR_BITS-1:0]       fifo_rd_reg;
    logic [OUT_CNT_BITS-1:0]       fifo_cnt_reg;

    logic                          issue;
    logic [OUT_CNT_BITS-1:0]       busy;
    logic                          ram_we;
    logic                          fwd_hit;
    logic [LP_WORD_BITS-1:0]       rd_fast;
    logic [LP_WORD_BITS-1:0]       rd_slow;
    logic [LP_WORD_BITS-1:0]       old_fast;
    logic [LP_WORD_BITS-1:0]       old_slow;
    logic [LP_WORD_BITS-1:0]       wr_fast;
    logic [LP_WORD_BITS-1:0]       wr_slow;
    lp_t                           lpf_new [NUM_CH];
    lp_t                           lps_new [NUM_CH];
    logic signed [BAND_BITS-1:0]   band_next [NUM_CH];
    logic signed [PROD_G_BITS-1:0] prod_next [NUM_CH];
    sample_t                       res_next [NUM_CH];
    out_item_t                     out_next;
    logic                          pop_out;

    // Issue only when the FIFO can take every transaction already in flight plus this one,
    // so the pipeline itself never has to stall.
    assign busy  = fifo_cnt_reg + OUT_CNT_BITS'(v1_reg) + OUT_CNT_BITS'(v2_reg)
                 + OUT_CNT_BITS'(v3_reg);
    assign issue = q_valid && (busy < OUT_CNT_BITS'(OUT_DEPTH));
    assign q_pop = issue;

    assign ram_we  = v1_reg && (s1_reg.op == OP_LOAD || s1_reg.op == OP_UPDATE);
    assign fwd_hit = fwd_v_reg && (fwd_addr_reg == s1_reg.addr);
    assign old_fast = fwd_hit ? fwd_fast_reg : rd_fast;
    assign old_slow = fwd_hit ? fwd_slow_reg : rd_slow;

    tbm_ram #(
        .WIDTH(LP_WORD_BITS),
        .DEPTH(STORE_ENTRIES)
    ) u_ram_fast (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.addr),
        .wr_data (wr_fast),
        .rd_en   (issue),
        .rd_addr (q_entry.addr),
        .rd_data (rd_fast)
    );

    tbm_ram #(
        .WIDTH(LP_WORD_BITS),
        .DEPTH(STORE_ENTRIES)
    ) u_ram_slow (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (s1_reg.addr),
        .wr_data (wr_slow),
        .rd_en   (issue),
        .rd_addr (q_entry.addr),
        .rd_data (rd_slow)
    );

    always_comb begin
        lp_t lpf_old;
        lp_t lps_old;
        lp_t x12;
        for (int k = 0; k < NUM_CH; k++) begin
            lpf_old = $signed(old_fast[k*LP_BITS +: LP_BITS]);
            lps_old = $signed(old_slow[k*LP_BITS +: LP_BITS]);
            x12     = {s1_reg.x[k], {LP_EXTRA{1'b0}}};
            case (s1_reg.op)
                OP_LOAD: begin
                    lpf_new[k] = x12;
                    lps_new[k] = x12;
                end
                OP_UPDATE: begin
                    lpf_new[k] = lp_step(lpf_old, x12, cfg.cutoff_fast);
                    lps_new[k] = lp_step(lps_old, x12, cfg.cutoff_slow);
                end
                default: begin
                    lpf_new[k] = lpf_old;
                    lps_new[k] = lps_old;
                end
            endcase
            wr_fast[k*LP_BITS +: LP_BITS] = lpf_new[k];
            wr_slow[k*LP_BITS +: LP_BITS] = lps_new[k];
            band_next[k] = {lpf_new[k][LP_BITS-1], lpf_new[k]}
                         - {lps_new[k][LP_BITS-1], lps_new[k]};
        end
    end

    always_comb begin
        for (int k = 0; k < NUM_CH; k++) begin
            prod_next[k] = band2_reg[k] * g2_reg;
        end
    end

    always_comb begin
        logic signed [PROD_C_BITS-1:0] pc;
        logic signed [WIDE_BITS-1:0]   wide;
        for (int k = 0; k < NUM_CH; k++) begin
            if (k == 0) begin
                pc   = '0;
                wide = (WIDE_BITS'(prod3_reg[k]) + (WIDE_BITS'(1) <<< (GAIN_SHIFT - 1)))
                       >>> GAIN_SHIFT;
            end else begin
                pc   = prod3_reg[k] * $signed({1'b0, cfg.chroma_atten});
                wide = (WIDE_BITS'(pc) + (WIDE_BITS'(1) <<< (CHROMA_SHIFT - 1)))
                       >>> CHROMA_SHIFT;
            end
            case (op3_reg)
                OP_LOAD:   res_next[k] = x3_reg[k];
                OP_UPDATE: res_next[k] = sat_sample(wide);
                default:   res_next[k] = '0;
            endcase
        end
        out_next.out_ch0 = res_next[0];
        out_next.out_ch1 = res_next[1];
        out_next.out_ch2 = res_next[2];
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (issue) begin
            s1_reg <= q_entry;
        end
        op2_reg <= s1_reg.op;
        x2_reg  <= s1_reg.x;
        g2_reg  <= s1_reg.gain;
        op3_reg <= op2_reg;
        x3_reg  <= x2_reg;
        for (int k = 0; k < NUM_CH; k++) begin
            band2_reg[k] <= band_next[k];
            prod3_reg[k] <= prod_next[k];
        end
        fwd_addr_reg <= s1_reg.addr;
        fwd_fast_reg <= wr_fast;
        fwd_slow_reg <= wr_slow;
        if (v3_reg) begin
            fifo_reg[fifo_wr_reg] <= out_next;
        end
    end

    assign pop_out = m_valid && m_ready;
    assign m_valid = (fifo_cnt_reg != '0);
    assign m_data  = fifo_reg[fifo_rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            fwd_v_reg    <= 1'b0;
            fifo_wr_reg  <= '0;
            fifo_rd_reg  <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            v1_reg    <= issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            fwd_v_reg <= ram_we;
            if (v3_reg) begin
                fifo_wr_reg <= fifo_wr_reg + OUT_PTR_BITS'(1);
            end
            if (pop_out) begin
                fifo_rd_reg <= fifo_rd_reg + OUT_PTR_BITS'(1);
            end
            if (v3_reg && !pop_out) begin
                fifo_cnt_reg <= fifo_cnt_reg + OUT_CNT_BITS'(1);
            end else if (pop_out && !v3_reg) begin
                fifo_cnt_reg <= fifo_cnt_reg - OUT_CNT_BITS'(1);
            end
        end
    end

endmodule

[rtl/tbm_checker.sv]
// Port-level checks for the band-pass magnifier top level, bound to it below.
// Depends on tbm_pkg for the port types and register map.
module tbm_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input tbm_pkg::out_item_t                m_data,
    input logic                              psel,
    input logic                              penable,
    input logic                              pwrite,
    input logic [tbm_pkg::CFG_ADDR_BITS-1:0] paddr,
    input logic [tbm_pkg::CFG_DATA_BITS-1:0] pwdata,
    input logic [tbm_pkg::CFG_DATA_BITS-1:0] prdata,
    input logic                              pready
);
    import tbm_pkg::*;

    // After reset there is no result pending and the front end has room.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("result pending or input blocked straight after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result transaction dropped or changed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready fell");

    // A write to the fast cutoff register reads back what was written.
    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready
            && paddr[CFG_ADDR_BITS-1:2] == REG_CUTOFF_FAST
        |=> !$stable(paddr) || prdata[COEF_BITS-1:0] == $past(pwdata[COEF_BITS-1:0]))
        else $error("cutoff register read-back differs from the value written");

    // With no input accepted right after reset, no result can appear at once.
    a_no_spurious: assert property (@(posedge aclk)
        !aresetn ##1 !(s_valid && s_ready) |=> !m_valid)
        else $error("result appeared without an input transaction");

endmodule

bind temporal_bandpass_magnifier_top tbm_checker u_tbm_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
);

[tb/tb_temporal_bandpass_magnifier_top.sv]
// Self-checking testbench of the temporal band-pass magnifier: a directed table, then random
// pixel streams under several register settings, each result checked against a predictor or a typed-in value.
// Depends on tbm_pkg and temporal_bandpass_magnifier_top.
`timescale 1ns / 100ps

module tb_temporal_bandpass_magnifier_top;
    import tbm_pkg::*;

    typedef struct packed {
        in_item_t  pix;
        logic      known;
        out_item_t want;
    } dir_row_t;

    // Where known is set, the result is obvious (pass-through or zeroing) and typed in here.
    localparam int DIR_ROWS = 18;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        {16'h0000, 3'd2, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1, 1'b1,
         16'h7FFF, 16'h8000, 16'h0000},
        {16'hFFFF, 3'd0, 16'hFFFF, 16'h0001, 16'h1234, 16'h7FFF, 1'b1, 1'b1,
         16'hFFFF, 16'h0001, 16'h1234},
        {16'h5A5A, 3'd7, 16'h0100, 16'hFF00, 16'h7FFF, 16'h8000, 1'b1, 1'b1,
         16'h0100, 16'hFF00, 16'h7FFF},
        {16'h0000, 3'd0, 16'h1111, 16'h2222, 16'h3333, 16'h0100, 1'b0, 1'b1, 48'h0},
        {16'h0000, 3'd4, 16'h7FFF, 16'h8000, 16'h4444, 16'h0A00, 1'b0, 1'b1, 48'h0},
        {16'hFFFF, 3'd7, 16'h8000, 16'h7FFF, 16'h0001, 16'h7FFF, 1'b0, 1'b1, 48'h0},
        {16'h0000, 3'd1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 48'h0},
        {16'h0000, 3'd3, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, 48'h0},
        {16'hFFFF, 3'd2, 16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 1'b0, 1'b0, 48'h0},
        {16'h5A5A, 3'd1, 16'h8000, 16'h7FFF, 16'h0000, 16'hFF00, 1'b0, 1'b0, 48'h0},
        {16'h5A5A, 3'd3, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b1, 48'h0},
        {16'hFFFF, 3'd3, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0A00, 1'b0, 1'b0, 48'h0},
        {16'h0000, 3'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b1, 48'h0},
        {16'h0000, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0, 1'b1, 48'h0},
        {16'h1234, 3'd5, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1, 1'b1,
         16'h8000, 16'h8000, 16'h8000},
        {16'h1234, 3'd2, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 48'h0},
        {16'h1234, 3'd3, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0, 1'b0, 48'h0},
        {16'h1234, 3'd1, 16'h0000, 16'h1000, 16'hF000, 16'h8001, 1'b0, 1'b0, 48'h0}
    };

    localparam int PHASES     = 7;
    localparam int PHASE_PIXS = 240;

    logic                     aclk    = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    in_item_t                 s_data  = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    out_item_t                m_data;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [CFG_ADDR_BITS-1:0] paddr   = '0;
    logic [CFG_DATA_BITS-1:0] pwdata  = '0;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    // Predictor state: both low-pass stores, the register copy and the loaded addresses.
    lp_t         fast_store [STORE_ENTRIES][NUM_CH];
    lp_t         slow_store [STORE_ENTRIES][NUM_CH];
    bit          store_loaded [STORE_ENTRIES];
    logic [15:0] loaded_addrs [$];
    cfg_t        active_cfg;

    out_item_t   pending_outputs [$];
    int          mismatch_count = 0;
    int          send_idle_pct  = 0;
    int          recv_idle_pct  = 0;

    temporal_bandpass_magnifier_top DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Round half up, then an arithmetic (flooring) shift.
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint lowpass_step(input longint lp, input longint x12,
                                            input longint coef);
        return lp + round_shift((x12 - lp) * coef, COEF_BITS);
    endfunction

    function automatic sample_t clamp_sample(input longint v);
        longint hi;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (v > hi) begin
            return sample_t'(hi);
        end else if (v < -hi - 1) begin
            return sample_t'(-hi - 1);
        end
        return sample_t'(v);
    endfunction

    function automatic out_item_t predict_magnified(input in_item_t pix);
        sample_t   smp [NUM_CH];
        sample_t   res [NUM_CH];
        longint    x12;
        longint    fast_v;
        longint    slow_v;
        longint    band;
        longint    gain;
        longint    cap;
        longint    atten;
        int        a;
        out_item_t o;
        smp[0] = pix.sample_ch0;
        smp[1] = pix.sample_ch1;
        smp[2] = pix.sample_ch2;
        a = pix.pixel_addr % STORE_ENTRIES;
        for (int k = 0; k < NUM_CH; k++) begin
            res[k] = '0;
        end
        if (pix.first_frame) begin
            if (!store_loaded[a]) begin
                store_loaded[a] = 1'b1;
                loaded_addrs.insert(loaded_addrs.size(), pix.pixel_addr);
            end
            for (int k = 0; k < NUM_CH; k++) begin
                x12 = smp[k];
                x12 = x12 <<< LP_EXTRA;
                fast_store[a][k] = lp_t'(x12);
                slow_store[a][k] = lp_t'(x12);
                res[k] = smp[k];
            end
        end else if (pix.level != 0 && pix.level < active_cfg.top_level) begin
            gain  = pix.level_gain;
            cap   = active_cfg.alpha_cap;
            atten = active_cfg.chroma_atten;
            if (cap < gain) begin
                gain = cap;
            end
            for (int k = 0; k < NUM_CH; k++) begin
                x12 = smp[k];
                x12 = x12 <<< LP_EXTRA;
                fast_v = lowpass_step(fast_store[a][k], x12, active_cfg.cutoff_fast);
                slow_v = lowpass_step(slow_store[a][k], x12, active_cfg.cutoff_slow);
                fast_store[a][k] = lp_t'(fast_v);
                slow_store[a][k] = lp_t'(slow_v);
                band = fast_v - slow_v;
                if (k == 0) begin
                    res[k] = clamp_sample(round_shift(band * gain, GAIN_SHIFT));
                end else begin
                    res[k] = clamp_sample(round_shift(band * gain * atten, CHROMA_SHIFT));
                end
            end
        end
        o.out_ch0 = res[0];
        o.out_ch1 = res[1];
        o.out_ch2 = res[2];
        return o;
    endfunction

    function automatic sample_t random_sample();
        if ($urandom_range(3) == 0) begin
            return sample_t'($urandom);
        end
        return sample_t'(int'($urandom_range(4095)) - 2048);
    endfunction

    // Mostly updates of already loaded pixels at in-band levels when the top level is 2 or more;
    // the rest is reloads, fresh addresses and out-of-band levels.
    function automatic in_item_t random_pixel();
        in_item_t pix;
        int       top;
        pix.first_frame = (loaded_addrs.size() < 8) || ($urandom_range(99) < 8);
        if (pix.first_frame && loaded_addrs.size() < 64 && $urandom_range(9) < 7) begin
            pix.pixel_addr = 16'($urandom);
        end else begin
            pix.pixel_addr = loaded_addrs[$urandom_range(loaded_addrs.size() - 1)];
        end
        top = active_cfg.top_level;
        if (top >= 2 && $urandom_range(99) < 75) begin
            pix.level = LEVEL_BITS'($urandom_range(top - 1, 1));
        end else begin
            pix.level = LEVEL_BITS'($urandom_range(7));
        end
        pix.sample_ch0 = random_sample();
        pix.sample_ch1 = random_sample();
        pix.sample_ch2 = random_sample();
        case ($urandom_range(3))
            0: begin
                pix.level_gain = 16'($urandom);
            end
            1: begin
                pix.level_gain = 16'($urandom_range(3072));
            end
            2: begin
                pix.level_gain = 16'(-int'($urandom_range(3072)));
            end
            default: begin
                pix.level_gain = 16'(int'(active_cfg.alpha_cap) + int'($urandom_range(8)) - 4);
            end
        endcase
        return pix;
    endfunction

    // Called and returns at a falling edge.
    task automatic send_pixel(input in_item_t pix, input logic known, input out_item_t want);
        out_item_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= pix;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predicted = predict_magnified(pix);
        pending_outputs.insert(pending_outputs.size(), known ? want : predicted);
        @(negedge aclk);
    endtask

    // Leaves psel and penable high; the caller closes the transfer after the last write.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        case (idx)
            REG_CUTOFF_FAST:  active_cfg.cutoff_fast  = value[COEF_BITS-1:0];
            REG_CUTOFF_SLOW:  active_cfg.cutoff_slow  = value[COEF_BITS-1:0];
            REG_ALPHA_CAP:    active_cfg.alpha_cap    = value[COEF_BITS-1:0];
            REG_CHROMA_ATTEN: active_cfg.chroma_atten = value[COEF_BITS-1:0];
            REG_TOP_LEVEL:    active_cfg.top_level    = value[LEVEL_BITS-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic apply_settings(input cfg_t setting);
        write_reg(REG_CUTOFF_FAST, 32'(setting.cutoff_fast));
        write_reg(REG_CUTOFF_SLOW, 32'(setting.cutoff_slow));
        write_reg(REG_ALPHA_CAP, 32'(setting.alpha_cap));
        write_reg(REG_CHROMA_ATTEN, 32'(setting.chroma_atten));
        write_reg(REG_TOP_LEVEL, 32'(setting.top_level));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Waits for every outstanding result, then lets the pipeline settle.
    task automatic drain_results();
        while (pending_outputs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic check_field(input string name, input sample_t want, input sample_t got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin : check_outputs
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("result transaction with no expectation outstanding");
                mismatch_count++;
            end else begin
                want = pending_outputs[0];
                pending_outputs.delete(0);
                check_field("out_ch0", want.out_ch0, m_data.out_ch0);
                check_field("out_ch1", want.out_ch1, m_data.out_ch1);
                check_field("out_ch2", want.out_ch2, m_data.out_ch2);
            end
        end
    end

    initial begin : stimulus
        dir_row_t row;
        cfg_t     setting;
        active_cfg.cutoff_fast  = RST_CUTOFF_FAST;
        active_cfg.cutoff_slow  = RST_CUTOFF_SLOW;
        active_cfg.alpha_cap    = RST_ALPHA_CAP;
        active_cfg.chroma_atten = RST_CHROMA_ATTEN;
        active_cfg.top_level    = RST_TOP_LEVEL;
        send_idle_pct = 16;
        recv_idle_pct = 72;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int n = 0; n < DIR_ROWS; n++) begin
            row = DIRECTED[n];
            send_pixel(row.pix, row.known, row.want);
        end
        s_valid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            drain_results();
            setting.cutoff_fast  = 16'($urandom);
            setting.cutoff_slow  = 16'($urandom);
            setting.alpha_cap    = 16'($urandom_range(16'h1000));
            setting.chroma_atten = 16'($urandom_range(16'h0400));
            setting.top_level    = LEVEL_BITS'($urandom_range(7, 2));
            case (ph)
                0: begin
                    setting = {16'h8000, 16'h0800, 16'h0400, 16'h00C0, 3'd6};
                end
                1: begin
                    setting = {16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 3'd7};
                end
                2: begin
                    setting = {16'h0000, 16'hFFFF, 16'h0000, 16'h0000, 3'd7};
                end
                3: begin
                    setting.top_level = 3'd1;
                end
                5: begin
                    setting.top_level = 3'd0;
                end
                default: ;
            endcase
            apply_settings(setting);
            send_idle_pct = (ph < 3) ? 16 : (ph < 5) ? 72 : 0;
            recv_idle_pct = (ph < 3) ? 72 : (ph < 5) ? 16 : 0;
            for (int n = 0; n < PHASE_PIXS; n++) begin
                send_pixel(random_pixel(), 1'b0, '0);
            end
            s_valid <= 1'b0;
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[temporal_bandpass_magnifier_top.f]
rtl/tbm_pkg.sv
rtl/tbm_ram.sv
rtl/tbm_cfg.sv
rtl/tbm_front.sv
rtl/tbm_back.sv
rtl/temporal_bandpass_magnifier_top.sv
rtl/tbm_checker.sv
tb/tb_temporal_bandpass_magnifier_top.sv
